// ----- design/frame_ring_bump_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// frame_ring_bump_allocator_macros
// assertion macros shared by the frame ring bump allocator modules
// ----------------------------------------------------------------------------
`ifndef FRAME_RING_BUMP_ALLOCATOR_MACROS_SVH
`define FRAME_RING_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FRBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frba: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define FRBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frba: next-cycle check failed");

`endif

// ----- design/frba_pkg.sv -----
// ----------------------------------------------------------------------------
// frba_pkg
// types, codes and constants of the frame ring bump allocator
// ----------------------------------------------------------------------------
`default_nettype none

package frba_pkg;

    // frames in flight and pool alignments (alignments are powers of two)
    localparam int NUM_FRAMES   = 2;
    localparam int VERTEX_ALIGN = 32;
    localparam int INDEX_ALIGN  = 16;

    localparam int SLOT_W   = $clog2(NUM_FRAMES);
    localparam int ALIGN_W  = 8;
    localparam int CAP_W    = 26;
    localparam int SIZE_W   = 23;
    localparam int OFFSET_W = 25;
    localparam int TAG_W    = 15;
    localparam int COUNT_W  = 24;
    localparam int ESIZE_W  = 8;
    localparam int HANDLE_W = 64;
    localparam int BYTES_W  = COUNT_W + ESIZE_W;

    localparam logic [ALIGN_W-1:0] VERTEX_ALIGN_M1 = ALIGN_W'(VERTEX_ALIGN - 1);
    localparam logic [ALIGN_W-1:0] INDEX_ALIGN_M1  = ALIGN_W'(INDEX_ALIGN - 1);
    localparam logic [CAP_W-1:0]   CAP_LIMIT       = CAP_W'(33554432);
    localparam logic [CAP_W-1:0]   VERTEX_CAP_RST  = CAP_W'(8388608);
    localparam logic [CAP_W-1:0]   INDEX_CAP_RST   = CAP_W'(4194304);
    localparam logic [SLOT_W-1:0]  LAST_SLOT       = SLOT_W'(NUM_FRAMES - 1);

    // configuration register indexes
    localparam logic CFG_VERTEX_CAP = 1'b0;
    localparam logic CFG_INDEX_CAP  = 1'b1;

    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_SWAP   = 2'd2
    } t_func;

    typedef enum logic [2:0] {
        STATUS_OK    = 3'd0,
        STATUS_EMPTY = 3'd1,
        STATUS_FULL  = 3'd2,
        STATUS_NULL  = 3'd3,
        STATUS_STALE = 3'd4
    } t_status;

    typedef struct packed {
        t_func               func;
        logic                pool;
        logic [COUNT_W-1:0]  count;
        logic [ESIZE_W-1:0]  elem_size;
        logic [HANDLE_W-1:0] handle_in;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [OFFSET_W-1:0] found_offset;
        logic [SIZE_W-1:0]   found_size;
        logic [1:0]          draw_slot_out;
        logic [CAP_W-1:0]    peak_vertex_bytes;
        logic [CAP_W-1:0]    peak_index_bytes;
    } t_out_item;

    typedef struct packed {
        logic [CAP_W-1:0] vertex_cap;
        logic [CAP_W-1:0] index_cap;
    } t_cfg;

endpackage

`default_nettype wire

// ----- design/frba_core.sv -----
// ----------------------------------------------------------------------------
// frba_core
// allocator state and the single-pass allocate / lookup / swap logic
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_ring_bump_allocator_macros.svh"

module frba_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_fire,
    input  wire frba_pkg::t_in_item i_item,
    input  wire frba_pkg::t_cfg  i_cfg,
    output frba_pkg::t_out_item  o_result
);
    import frba_pkg::*;

    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic [SLOT_W-1:0] r_draw_slot, n_draw_slot;
    logic [TAG_W-1:0]  r_frame_tag, n_frame_tag;
    logic [CAP_W-1:0]  r_vertex_used [NUM_FRAMES];
    logic [CAP_W-1:0]  n_vertex_used [NUM_FRAMES];
    logic [CAP_W-1:0]  r_index_used [NUM_FRAMES];
    logic [CAP_W-1:0]  n_index_used [NUM_FRAMES];
    logic [CAP_W-1:0]  r_peak_vertex, n_peak_vertex;
    logic [CAP_W-1:0]  r_peak_index, n_peak_index;

    logic [ALIGN_W-1:0] w_align_m1;
    logic [BYTES_W-1:0] w_bytes;
    logic [BYTES_W:0]   w_round_sum;
    logic [BYTES_W:0]   w_rounded;
    logic [CAP_W-1:0]   w_used;
    logic [CAP_W-1:0]   w_cap;
    logic [CAP_W-1:0]   w_cap_eff;
    logic [CAP_W:0]     w_sum;
    logic               w_over;
    logic [TAG_W-1:0]   w_prev_tag;

    // size rounding: product, then up to the pool alignment
    assign w_align_m1  = i_item.pool ? INDEX_ALIGN_M1 : VERTEX_ALIGN_M1;
    assign w_bytes     = {{ESIZE_W{1'b0}}, i_item.count} * {{COUNT_W{1'b0}}, i_item.elem_size};
    assign w_round_sum = {1'b0, w_bytes} + (BYTES_W + 1)'(w_align_m1);
    assign w_rounded   = w_round_sum & ~((BYTES_W + 1)'(w_align_m1));

    // bump check against the clamped capacity
    assign w_used    = i_item.pool ? r_index_used[r_write_slot] : r_vertex_used[r_write_slot];
    assign w_cap     = i_item.pool ? i_cfg.index_cap : i_cfg.vertex_cap;
    assign w_cap_eff = (w_cap > CAP_LIMIT) ? CAP_LIMIT : w_cap;
    assign w_sum     = {1'b0, w_used} + (CAP_W + 1)'(w_rounded[SIZE_W-1:0]);
    assign w_over    = (|w_rounded[BYTES_W:SIZE_W]) || (w_sum > {1'b0, w_cap_eff});

    assign w_prev_tag = r_frame_tag - TAG_W'(1);

    always_comb begin
        n_write_slot  = r_write_slot;
        n_draw_slot   = r_draw_slot;
        n_frame_tag   = r_frame_tag;
        n_vertex_used = r_vertex_used;
        n_index_used  = r_index_used;
        n_peak_vertex = r_peak_vertex;
        n_peak_index  = r_peak_index;

        o_result = '0;
        o_result.status = STATUS_OK;

        case (i_item.func)
            FUNC_ALLOC: begin
                if (w_rounded == '0) begin
                    o_result.status = STATUS_EMPTY;
                end else if (w_over) begin
                    o_result.status = STATUS_FULL;
                end else begin
                    if (i_item.pool) begin
                        n_index_used[r_write_slot] = w_sum[CAP_W-1:0];
                    end else begin
                        n_vertex_used[r_write_slot] = w_sum[CAP_W-1:0];
                    end
                    o_result.handle_out = {r_frame_tag, w_used[OFFSET_W-1:0],
                                           w_rounded[SIZE_W-1:0], 1'b0};
                end
            end
            FUNC_LOOKUP: begin
                if (i_item.handle_in == '0) begin
                    o_result.status = STATUS_NULL;
                end else if (i_item.handle_in[HANDLE_W-1 -: TAG_W] != w_prev_tag) begin
                    o_result.status = STATUS_STALE;
                end else begin
                    o_result.found_offset = i_item.handle_in[SIZE_W+OFFSET_W:SIZE_W+1];
                    o_result.found_size   = i_item.handle_in[SIZE_W:1];
                end
            end
            FUNC_SWAP: begin
                if (r_vertex_used[r_write_slot] > r_peak_vertex) begin
                    n_peak_vertex = r_vertex_used[r_write_slot];
                end
                if (r_index_used[r_write_slot] > r_peak_index) begin
                    n_peak_index = r_index_used[r_write_slot];
                end
                n_draw_slot  = r_write_slot;
                n_frame_tag  = r_frame_tag + TAG_W'(1);
                n_write_slot = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + SLOT_W'(1);
                n_vertex_used[n_write_slot] = '0;
                n_index_used[n_write_slot]  = '0;
            end
            default: begin
            end
        endcase

        o_result.draw_slot_out     = 2'(n_draw_slot);
        o_result.peak_vertex_bytes = n_peak_vertex;
        o_result.peak_index_bytes  = n_peak_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot  <= '0;
            r_draw_slot   <= '0;
            r_frame_tag   <= '0;
            r_peak_vertex <= '0;
            r_peak_index  <= '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_vertex_used[i] <= '0;
                r_index_used[i]  <= '0;
            end
        end else if (i_fire) begin
            r_write_slot  <= n_write_slot;
            r_draw_slot   <= n_draw_slot;
            r_frame_tag   <= n_frame_tag;
            r_peak_vertex <= n_peak_vertex;
            r_peak_index  <= n_peak_index;
            r_vertex_used <= n_vertex_used;
            r_index_used  <= n_index_used;
        end
    end

    // a granted allocation always carries a non-null handle
    `FRBA_ASSERT_SAME(a_alloc_handle, i_clk, i_rst_n,
        i_fire && i_item.func == FUNC_ALLOC && o_result.status == STATUS_OK,
        o_result.handle_out != '0)
    // a swap leaves the new write slot empty in both pools
    `FRBA_ASSERT_NEXT(a_swap_clears, i_clk, i_rst_n,
        i_fire && i_item.func == FUNC_SWAP,
        r_vertex_used[r_write_slot] == '0 && r_index_used[r_write_slot] == '0)
    // high-water marks never fall
    `FRBA_ASSERT_NEXT(a_peak_rises, i_clk, i_rst_n, 1'b1,
        r_peak_vertex >= $past(r_peak_vertex) && r_peak_index >= $past(r_peak_index))

endmodule

`default_nettype wire

// ----- design/frame_ring_bump_allocator.sv -----
// ----------------------------------------------------------------------------
// frame_ring_bump_allocator
// per-frame linear bump allocator for a vertex pool and an index pool
// ----------------------------------------------------------------------------
// One result item per input item, in order. The block takes one item per
// cycle unless the input side stalls; a taken item sits in the input register
// and, once the result register is free, passes through the allocate /
// lookup / swap logic into the result register. The pass is one product of
// count and element size, a round-up to the pool alignment and one add and
// compare against the clamped slot capacity. The input side stalls only while
// both the input and result registers are full and the result is stalled.
// Capacities are to be written through the config port only while the block
// is idle, not enforced by the block. Index 0: vertex pool, 1: index pool.
// ----------------------------------------------------------------------------
`default_nettype none
`include "frame_ring_bump_allocator_macros.svh"

module frame_ring_bump_allocator (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // item input channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire frba_pkg::t_in_item i_in,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output frba_pkg::t_out_item    o_out,
    // capacity write port
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_index,
    input  wire [frba_pkg::CAP_W-1:0] i_cfg_wdata
);
    import frba_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_item  r_in;
    // result register
    logic      r_out_valid;
    t_out_item r_out;
    // capacity registers
    t_cfg      r_cfg;

    logic      w_out_free;
    logic      w_fire;
    t_out_item w_result;

    // the result register can load when empty or being drained this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    frba_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= w_fire;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    // capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertex_cap <= VERTEX_CAP_RST;
            r_cfg.index_cap  <= INDEX_CAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_CAP: r_cfg.vertex_cap <= i_cfg_wdata;
                CFG_INDEX_CAP:  r_cfg.index_cap  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // an item that moves through the logic lands in the result register
    `FRBA_ASSERT_NEXT(a_fire_loads, i_clk, i_rst_n, w_fire, r_out_valid)
    // input stall only with a full pipe behind a stalled result
    `FRBA_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_out_valid && i_out_stall)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the frame ring bump allocator: directed items cover
// empty, oversized and full requests, null, stale and good lookups, swaps and
// the unused function code; capacity writes go through zero, small values,
// the clamp limit and the 26-bit maximum; random traffic runs under four
// idle/stall mixes and one long result hold-off; every result is compared
// field by field against an in-bench prediction of the allocator
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frba_pkg::*;

    // code the block leaves unassigned; it must answer ok with zero handle and lookup fields
    localparam t_func FUNC_UNUSED = t_func'(2'd3);

    localparam int QUIET_LIMIT      = 2000;  // cycles with no item moving
    localparam int RANDOM_PER_PHASE = 205;
    localparam int HOLD_CYCLES      = 60;
    localparam int HANDLE_KEEP      = 24;    // recent handles kept for lookups

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         in_item = '0;
    logic             o_out_valid;
    logic             out_stall = 1'b0;
    t_out_item        o_out;
    logic             cfg_we = 1'b0;
    logic             cfg_index = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    // idle mix and the receiver hold-off request
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;

    int fault_count = 0;
    int quiet_cycles = 0;

    // allocator state as the bench expects it
    logic [CAP_W-1:0] cap_vertex;
    logic [CAP_W-1:0] cap_index;
    logic [31:0]      frame_ctr;
    int               write_idx;
    int               draw_idx;
    logic [CAP_W-1:0] vtx_used [NUM_FRAMES];
    logic [CAP_W-1:0] idx_used [NUM_FRAMES];
    logic [31:0]      allocs_in_slot [NUM_FRAMES];
    logic [CAP_W-1:0] peak_vtx;
    logic [CAP_W-1:0] peak_idx;

    t_out_item        due_results [$];
    logic [63:0]      issued_handles [$];

    frame_ring_bump_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // allocator prediction
    // ------------------------------------------------------------------------

    task automatic clear_slot(input int s);
        vtx_used[s] = '0;
        idx_used[s] = '0;
        allocs_in_slot[s] = '0;
    endtask

    task automatic allocator_reset();
        cap_vertex = VERTEX_CAP_RST;
        cap_index  = INDEX_CAP_RST;
        frame_ctr  = '0;
        write_idx  = 0;
        draw_idx   = 0;
        for (int s = 0; s < NUM_FRAMES; s++) clear_slot(s);
        peak_vtx = '0;
        peak_idx = '0;
    endtask

    // one item in, the result it must produce out; allocator state advances
    task automatic allocator_step(input t_in_item it, output t_out_item res);
        logic [63:0] align;
        logic [63:0] rounded;
        logic [63:0] cap;
        logic [63:0] used;
        logic [14:0] prev_tag;
        int          s;
        res = '0;
        res.status = STATUS_OK;
        s = write_idx;
        case (it.func)
            FUNC_ALLOC: begin
                align = it.pool ? 64'(INDEX_ALIGN) : 64'(VERTEX_ALIGN);
                rounded = 64'(it.count) * 64'(it.elem_size);
                rounded = ((rounded + align - 1) / align) * align;
                cap = it.pool ? 64'(cap_index) : 64'(cap_vertex);
                if (cap > 64'(CAP_LIMIT)) cap = 64'(CAP_LIMIT);
                used = it.pool ? 64'(idx_used[s]) : 64'(vtx_used[s]);
                if (rounded == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (rounded > 64'h7fffff || used + rounded > cap) begin
                    // counter stays put on overflow
                    res.status = STATUS_FULL;
                end else begin
                    if (it.pool) idx_used[s] = CAP_W'(used + rounded);
                    else vtx_used[s] = CAP_W'(used + rounded);
                    allocs_in_slot[s] = allocs_in_slot[s] + 1;
                    res.handle_out = {frame_ctr[14:0], used[24:0], rounded[22:0], 1'b0};
                    issued_handles.push_back(res.handle_out);
                    if (issued_handles.size() > HANDLE_KEEP) void'(issued_handles.pop_front());
                end
            end
            FUNC_LOOKUP: begin
                prev_tag = frame_ctr[14:0] - 15'd1;
                if (it.handle_in == '0) begin
                    res.status = STATUS_NULL;
                end else if (it.handle_in[63:49] != prev_tag) begin
                    res.status = STATUS_STALE;
                end else begin
                    res.found_offset = it.handle_in[48:24];
                    res.found_size   = it.handle_in[23:1];
                end
            end
            FUNC_SWAP: begin
                if (vtx_used[s] > peak_vtx) peak_vtx = vtx_used[s];
                if (idx_used[s] > peak_idx) peak_idx = idx_used[s];
                draw_idx = s;
                frame_ctr = frame_ctr + 1;
                write_idx = int'(frame_ctr % NUM_FRAMES);
                clear_slot(write_idx);
            end
            default: ;
        endcase
        res.draw_slot_out     = 2'(draw_idx);
        res.peak_vertex_bytes = peak_vtx;
        res.peak_index_bytes  = peak_idx;
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s expected %h got %h", what, want, got);
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        if (got.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.handle_out !== want.handle_out)
            report_mismatch("handle_out", want.handle_out, got.handle_out);
        if (got.found_offset !== want.found_offset)
            report_mismatch("found_offset", 64'(want.found_offset), 64'(got.found_offset));
        if (got.found_size !== want.found_size)
            report_mismatch("found_size", 64'(want.found_size), 64'(got.found_size));
        if (got.draw_slot_out !== want.draw_slot_out)
            report_mismatch("draw_slot_out", 64'(want.draw_slot_out),
                            64'(got.draw_slot_out));
        if (got.peak_vertex_bytes !== want.peak_vertex_bytes)
            report_mismatch("peak_vertex_bytes", 64'(want.peak_vertex_bytes),
                            64'(got.peak_vertex_bytes));
        if (got.peak_index_bytes !== want.peak_index_bytes)
            report_mismatch("peak_index_bytes", 64'(want.peak_index_bytes),
                            64'(got.peak_index_bytes));
    endtask

    // both handshakes are seen at the rising edge, before the block updates;
    // the result side is checked first, then the accepted item is predicted
    always @(posedge i_clk) begin : handshake_watch
        t_out_item want;
        logic      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid === 1'b1 && !out_stall) begin
                moved = 1'b1;
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing due, handle", '0, o_out.handle_out);
                end else begin
                    want = due_results.pop_front();
                    compare_result(want, o_out);
                end
            end
            if (in_valid && o_in_stall === 1'b0) begin
                moved = 1'b1;
                allocator_step(in_item, want);
                due_results.push_back(want);
            end
            // watchdog: a run that stops moving items is a failure
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            out_stall <= 1'b1;
            hold_len <= hold_len - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // offer one item, with random sender gaps first; valid stays high on return
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // drop valid and wait until every result has come, plus the pipe depth
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacities(input logic [CAP_W-1:0] vtx, input logic [CAP_W-1:0] idx);
        wait_drained();
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_VERTEX_CAP;
        cfg_wdata <= vtx;
        @(negedge i_clk);
        cfg_index <= CFG_INDEX_CAP;
        cfg_wdata <= idx;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cap_vertex = vtx;
        cap_index  = idx;
    endtask

    function automatic t_in_item alloc_item(input logic pool, input logic [23:0] count,
                                            input logic [7:0] esize);
        t_in_item it;
        it = '0;
        it.func = FUNC_ALLOC;
        it.pool = pool;
        it.count = count;
        it.elem_size = esize;
        return it;
    endfunction

    function automatic t_in_item lookup_item(input logic [63:0] handle);
        t_in_item it;
        it = '0;
        it.func = FUNC_LOOKUP;
        it.handle_in = handle;
        return it;
    endfunction

    function automatic t_in_item swap_item();
        t_in_item it;
        it = '0;
        it.func = FUNC_SWAP;
        return it;
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;                     // above the clamp
            2: return CAP_LIMIT;
            3: return CAP_W'($urandom_range(1, 4096));
            4: return CAP_W'($urandom_range(4096, 65536));
            5: return CAP_W'(64);
            6: return CAP_W'($urandom_range(0, 1 << 20));
            default: return CAP_W'($urandom);
        endcase
    endfunction

    // mostly small allocations so pools fill, half of the lookups of real handles
    function automatic t_in_item random_item();
        t_in_item    it;
        int          pick;
        logic [14:0] prev_tag;
        it = '0;
        it.pool = 1'($urandom_range(0, 1));
        it.count = 24'($urandom);
        it.elem_size = 8'($urandom_range(0, 255));
        it.handle_in = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            it.func = FUNC_ALLOC;
            case ($urandom_range(0, 9))
                0: ;                                   // full-width count
                1: it.count = ($urandom_range(0, 1) == 0) ? '0 : '1;
                default: it.count = 24'($urandom_range(0, 48));
            endcase
        end else if (pick < 80) begin
            it.func = FUNC_LOOKUP;
            prev_tag = frame_ctr[14:0] - 15'd1;
            case ($urandom_range(0, 5))
                0, 1, 2: begin
                    if (issued_handles.size() > 0)
                        it.handle_in = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
                end
                3: it.handle_in[63:49] = prev_tag;
                4: it.handle_in = '0;
                default: ;                             // random, almost surely stale
            endcase
        end else if (pick < 92) begin
            it.func = FUNC_SWAP;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty and oversized requests, exact fill, null/stale/good lookups, swaps
    task automatic test_directed_items();
        t_in_item odd;
        send_item(alloc_item(1'b0, 24'd0, 8'd255));           // empty request
        send_item(alloc_item(1'b1, 24'hffffff, 8'd0));        // empty request
        send_item(alloc_item(1'b0, 24'd1, 8'd1));             // rounds to 32
        send_item(alloc_item(1'b1, 24'd1, 8'd1));             // rounds to 16
        send_item(alloc_item(1'b0, 24'hffffff, 8'd255));      // size past 23 bits
        send_item(alloc_item(1'b0, 24'h7fffe1, 8'd1));        // rounds past 23 bits
        send_item(alloc_item(1'b0, 24'd262143, 8'd32));       // fills vertex exactly
        send_item(alloc_item(1'b0, 24'd1, 8'd1));             // vertex full
        send_item(alloc_item(1'b1, 24'h3ffff, 8'd16));        // fills index exactly
        send_item(alloc_item(1'b1, 24'd1, 8'd17));            // index full
        send_item(lookup_item(64'd0));                        // null handle
        send_item(lookup_item({15'd0, 25'd32, 23'd32, 1'b0})); // stale in frame 0
        send_item(lookup_item('1));                           // tag wraps to all ones
        odd = lookup_item({15'h7fff, 25'd5, 23'd7, 1'b1});
        odd.pool = 1'b1;                                      // pool ignored on lookup
        send_item(odd);
        odd = '1;
        odd.func = FUNC_UNUSED;
        send_item(odd);
        send_item(swap_item());
        send_item(lookup_item({15'd0, 25'd32, 23'h7fffe0, 1'b0}));
        send_item(lookup_item({15'd1, 25'd0, 23'd32, 1'b0}));
        send_item(alloc_item(1'b0, 24'd3, 8'd7));
        send_item(swap_item());
        send_item(swap_item());
        send_item(alloc_item(1'b1, 24'd5, 8'd5));
        send_item(alloc_item(1'b0, 24'd1, 8'd255));
    endtask

    // zero capacity, the clamp and 26-bit maximum, then tiny pools
    task automatic test_capacity_limits();
        set_capacities('0, '0);
        send_item(alloc_item(1'b0, 24'd1, 8'd1));
        send_item(alloc_item(1'b1, 24'd1, 8'd1));
        send_item(alloc_item(1'b0, 24'd0, 8'd0));

        // vertex above the clamp acts as the clamp; fill both to the top
        set_capacities('1, CAP_LIMIT);
        send_item(swap_item());
        repeat (5) send_item(alloc_item(1'b0, 24'd262143, 8'd32));
        send_item(alloc_item(1'b0, 24'd4, 8'd32));
        send_item(alloc_item(1'b0, 24'd1, 8'd1));
        repeat (4) send_item(alloc_item(1'b1, 24'h7ffff, 8'd16));
        send_item(alloc_item(1'b1, 24'd4, 8'd16));
        send_item(alloc_item(1'b1, 24'd1, 8'd1));
        send_item(swap_item());

        set_capacities(CAP_W'(64), CAP_W'(16));
        send_item(swap_item());
        send_item(alloc_item(1'b0, 24'd1, 8'd32));
        send_item(alloc_item(1'b0, 24'd1, 8'd33));
        send_item(alloc_item(1'b0, 24'd1, 8'd1));
        send_item(alloc_item(1'b1, 24'd1, 8'd16));
        send_item(alloc_item(1'b1, 24'd1, 8'd1));

        set_capacities(VERTEX_CAP_RST, INDEX_CAP_RST);
    endtask

    // results held off while items keep coming, then a full drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_item(random_item());
        send_item(random_item());
        hold_len = HOLD_CYCLES;
        repeat (30) send_item(random_item());
        wait_drained();
    endtask

    // random traffic under each idle mix, fresh capacities per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            set_capacities(pick_capacity(), pick_capacity());
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            repeat (RANDOM_PER_PHASE) send_item(random_item());
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        allocator_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_items();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        fault_count += due_results.size();
        if (fault_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
